@@ design/brlt_pkg.sv @@
// Package for the block request latency tracker.
// Holds event codes, controller states and the command/status structs.
package brlt_pkg;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_ISSUE    = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic scan_start;
    logic scan_step;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } ctrl_status_t;

endpackage

@@ design/block_request_latency_tracker.sv @@
// Block request latency tracker: each insert, issue or complete event gives one
// record with device depth and, on complete, device and queue latency. After
// reset the block is busy while it clears the pending table. Each event then
// probes the pending table RAM sequentially, one entry per cycle. The result
// appears for one cycle on done; the receiver cannot stall it. Event kind 3
// gives no result.
// Depends on brlt_pkg, brlt_ctrl and brlt_datapath.
module block_request_latency_tracker
  import brlt_pkg::*;
#(
  parameter int PENDING_ENTRIES = 256,
  parameter int DEVICE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [31:0]        device_number,
  input  logic [47:0]        start_sector,
  input  logic [22:0]        sector_count,
  input  logic [31:0]        byte_count,
  input  logic signed [12:0] error_code,
  input  logic [62:0]        timestamp_ns,
  output logic               done,
  output logic [1:0]         event_kind,
  output logic [11:0]        dev_major,
  output logic [19:0]        dev_minor,
  output logic [47:0]        out_sector,
  output logic [22:0]        out_count,
  output logic [31:0]        out_bytes,
  output logic signed [12:0] out_error,
  output logic [62:0]        device_latency_ns,
  output logic [62:0]        queue_latency_ns,
  output logic [15:0]        queue_depth
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  brlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  brlt_datapath #(
    .PENDING_ENTRIES (PENDING_ENTRIES),
    .DEVICE_SLOTS    (DEVICE_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .req_type          (req_type),
    .device_number     (device_number),
    .start_sector      (start_sector),
    .sector_count      (sector_count),
    .byte_count        (byte_count),
    .error_code        (error_code),
    .timestamp_ns      (timestamp_ns),
    .done              (done),
    .event_kind        (event_kind),
    .dev_major         (dev_major),
    .dev_minor         (dev_minor),
    .out_sector        (out_sector),
    .out_count         (out_count),
    .out_bytes         (out_bytes),
    .out_error         (out_error),
    .device_latency_ns (device_latency_ns),
    .queue_latency_ns  (queue_latency_ns),
    .queue_depth       (queue_depth)
  );

endmodule

@@ design/brlt_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module brlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/brlt_ctrl.sv @@
// Controller state machine for the block request latency tracker.
// Depends on brlt_pkg.
module brlt_ctrl
  import brlt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [1:0]   req_type,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd,
  output logic         busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && req_type != KIND_NONE) begin
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/brlt_datapath.sv @@
// Datapath: pending table in RAM, device depth slots, latency arithmetic.
// Depends on brlt_pkg and brlt_ram.
module brlt_datapath
  import brlt_pkg::*;
#(
  parameter int PENDING_ENTRIES = 256,
  parameter int DEVICE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output ctrl_status_t       status,
  input  logic [1:0]         req_type,
  input  logic [31:0]        device_number,
  input  logic [47:0]        start_sector,
  input  logic [22:0]        sector_count,
  input  logic [31:0]        byte_count,
  input  logic signed [12:0] error_code,
  input  logic [62:0]        timestamp_ns,
  output logic               done,
  output logic [1:0]         event_kind,
  output logic [11:0]        dev_major,
  output logic [19:0]        dev_minor,
  output logic [47:0]        out_sector,
  output logic [22:0]        out_count,
  output logic [31:0]        out_bytes,
  output logic signed [12:0] out_error,
  output logic [62:0]        device_latency_ns,
  output logic [62:0]        queue_latency_ns,
  output logic [15:0]        queue_depth
);

  localparam int AW = $clog2(PENDING_ENTRIES);
  localparam int DW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  // entry word: valid, ins, iss, dev, sec, cnt, insert_time, issue_time
  localparam int EW = 3 + 32 + 48 + 23 + 63 + 63;

  logic [1:0]         kind;
  logic [31:0]        dev;
  logic [47:0]        sec;
  logic [22:0]        cnt;
  logic [31:0]        bytes;
  logic signed [12:0] err;
  logic [62:0]        now;

  logic [AW:0]   addr_cnt;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          rd_valid;
  logic [AW-1:0] rd_addr;

  logic          hit, free_found;
  logic [AW-1:0] hit_idx, free_idx;
  logic [EW-1:0] hit_word;

  logic          r_valid;
  logic [31:0]   r_dev;
  logic [47:0]   r_sec;
  logic [22:0]   r_cnt;

  logic          dev_valid [DEVICE_SLOTS];
  logic [31:0]   dev_id    [DEVICE_SLOTS];
  logic [15:0]   dev_depth [DEVICE_SLOTS];

  logic          d_hit, d_free;
  logic [DW-1:0] d_idx, d_free_idx;
  logic          w_ins, w_iss;
  logic [62:0]   h_itime, h_stime;
  logic [15:0]   depth_inc, depth_dec;

  assign r_valid = ram_rdata[EW-1];
  assign r_dev   = ram_rdata[EW-4 -: 32];
  assign r_sec   = ram_rdata[EW-36 -: 48];
  assign r_cnt   = ram_rdata[EW-84 -: 23];
  assign {w_ins, w_iss} = hit_word[EW-2 -: 2];
  assign h_itime = hit_word[125:63];
  assign h_stime = hit_word[62:0];

  assign depth_inc = dev_depth[d_idx] + 16'(dev_depth[d_idx] != DEPTH_MAX);
  assign depth_dec = dev_depth[d_idx] - 16'(dev_depth[d_idx] != 16'd0);

  brlt_ram #(.WIDTH(EW), .DEPTH(PENDING_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign status.clear_done = addr_cnt == (AW+1)'(PENDING_ENTRIES - 1);
  assign status.scan_done  = rd_valid && (rd_addr == AW'(PENDING_ENTRIES - 1));

  always_comb begin
    d_hit = 1'b0;
    d_free = 1'b0;
    d_idx = '0;
    d_free_idx = '0;
    for (int i = DEVICE_SLOTS - 1; i >= 0; i--) begin
      if (dev_valid[i] && dev_id[i] == dev) begin
        d_hit = 1'b1;
        d_idx = DW'(i);
      end
      if (!dev_valid[i]) begin
        d_free = 1'b1;
        d_free_idx = DW'(i);
      end
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = addr_cnt[AW-1:0];
    ram_wdata = '0;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.update) begin
      priority if (kind == KIND_COMPLETE) begin
        ram_addr = hit_idx;
        ram_we = hit;
        ram_wdata = '0;
      end else if (hit || free_found) begin
        ram_addr = hit ? hit_idx : free_idx;
        ram_we = 1'b1;
        if (hit) begin
          ram_wdata = hit_word;
        end else begin
          ram_wdata = {3'b100, dev, sec, cnt, 63'd0, 63'd0};
        end
        if (kind == KIND_INSERT) begin
          ram_wdata[EW-2] = 1'b1;
          ram_wdata[125:63] = now;
        end else begin
          ram_wdata[EW-3] = 1'b1;
          ram_wdata[62:0] = now;
        end
      end else begin
        ram_we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt <= '0;
      rd_valid <= 1'b0;
      done <= 1'b0;
      for (int i = 0; i < DEVICE_SLOTS; i++) dev_valid[i] <= 1'b0;
    end else begin
      done <= cmd.emit;
      rd_valid <= cmd.scan_step && !status.scan_done;
      rd_addr <= addr_cnt[AW-1:0];
      if (cmd.clear_step) begin
        addr_cnt <= addr_cnt + (AW+1)'(1);
      end
      if (cmd.scan_start) begin
        addr_cnt <= '0;
        hit <= 1'b0;
        free_found <= 1'b0;
        kind <= req_type;
        dev <= device_number;
        sec <= start_sector;
        cnt <= sector_count;
        bytes <= byte_count;
        err <= error_code;
        now <= timestamp_ns;
      end
      if (cmd.scan_step) begin
        if (!addr_cnt[AW]) addr_cnt <= addr_cnt + (AW+1)'(1);
        if (rd_valid) begin
          if (!hit && r_valid && r_dev == dev && r_sec == sec && r_cnt == cnt) begin
            hit <= 1'b1;
            hit_idx <= rd_addr;
            hit_word <= ram_rdata;
          end
          if (!free_found && !r_valid) begin
            free_found <= 1'b1;
            free_idx <= rd_addr;
          end
        end
      end
      if (cmd.update) begin
        event_kind <= kind;
        dev_major <= dev[31:20];
        dev_minor <= dev[19:0];
        out_sector <= sec;
        out_count <= cnt;
        out_bytes <= bytes;
        out_error <= '0;
        device_latency_ns <= '0;
        queue_latency_ns <= '0;
        queue_depth <= '0;
        unique case (kind)
          KIND_INSERT: begin
            if (d_hit) queue_depth <= dev_depth[d_idx];
          end
          KIND_ISSUE: begin
            if (d_hit) begin
              dev_depth[d_idx] <= depth_inc;
              queue_depth <= depth_inc;
            end else if (d_free) begin
              dev_valid[d_free_idx] <= 1'b1;
              dev_id[d_free_idx] <= dev;
              dev_depth[d_free_idx] <= 16'd1;
              queue_depth <= 16'd1;
            end
          end
          KIND_COMPLETE: begin
            out_bytes <= {cnt[22:0], 9'd0};
            out_error <= err;
            if (hit && w_iss) begin
              if (now >= h_stime) device_latency_ns <= now - h_stime;
              if (w_ins && h_stime >= h_itime) queue_latency_ns <= h_stime - h_itime;
            end
            if (d_hit) begin
              dev_depth[d_idx] <= depth_dec;
              queue_depth <= depth_dec;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ verif/tb_block_request_latency_tracker.sv @@
// Testbench for block_request_latency_tracker: a directed table, then random
// insert/issue/complete traffic, with some kind-3 events, checked against an in-bench tracking model.
// Depends on brlt_pkg and the block_request_latency_tracker RTL.
module tb_block_request_latency_tracker;
  import brlt_pkg::*;

  localparam int NUM_PENDING = 256;
  localparam int NUM_DEVS    = 16;
  localparam int RAND_ITEMS  = 1800;
  localparam int CYCLE_LIMIT = 4000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = KIND_INSERT;
  logic [31:0]        device_number = '0;
  logic [47:0]        start_sector = '0;
  logic [22:0]        sector_count = '0;
  logic [31:0]        byte_count = '0;
  logic signed [12:0] error_code = '0;
  logic [62:0]        timestamp_ns = '0;
  logic               done;
  logic [1:0]         event_kind;
  logic [11:0]        dev_major;
  logic [19:0]        dev_minor;
  logic [47:0]        out_sector;
  logic [22:0]        out_count;
  logic [31:0]        out_bytes;
  logic signed [12:0] out_error;
  logic [62:0]        device_latency_ns;
  logic [62:0]        queue_latency_ns;
  logic [15:0]        queue_depth;

  block_request_latency_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .device_number(device_number),
    .start_sector(start_sector), .sector_count(sector_count),
    .byte_count(byte_count), .error_code(error_code),
    .timestamp_ns(timestamp_ns), .done(done), .event_kind(event_kind),
    .dev_major(dev_major), .dev_minor(dev_minor), .out_sector(out_sector),
    .out_count(out_count), .out_bytes(out_bytes), .out_error(out_error),
    .device_latency_ns(device_latency_ns), .queue_latency_ns(queue_latency_ns),
    .queue_depth(queue_depth)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] major;
    logic [19:0] minor;
    logic [47:0] sector;
    logic [22:0] count;
    logic [31:0] bytes;
    logic [12:0] err;
    logic [62:0] dev_lat;
    logic [62:0] q_lat;
    logic [15:0] depth;
  } record_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] dev;
    logic [47:0] sector;
    logic [22:0] count;
    logic [31:0] bytes;
    logic [12:0] err;
    logic [62:0] ts;
    bit          typed;
    logic [62:0] dev_lat;
    logic [62:0] q_lat;
    logic [15:0] depth;
  } row_t;

  typedef struct {
    logic [31:0] dev;
    logic [47:0] sector;
    logic [22:0] count;
  } req_key_t;

  bit          pend_valid [NUM_PENDING];
  logic [31:0] pend_dev   [NUM_PENDING];
  logic [47:0] pend_sec   [NUM_PENDING];
  logic [22:0] pend_cnt   [NUM_PENDING];
  bit          pend_hins  [NUM_PENDING];
  logic [62:0] pend_tins  [NUM_PENDING];
  bit          pend_hiss  [NUM_PENDING];
  logic [62:0] pend_tiss  [NUM_PENDING];
  bit          slot_valid [NUM_DEVS];
  logic [31:0] slot_id    [NUM_DEVS];
  logic [15:0] slot_depth [NUM_DEVS];

  record_t  expected_records [$];
  req_key_t open_keys [$];
  logic [31:0] dev_pool [24];
  int errors = 0;
  int cycles = 0;
  int kind_count [4];
  bit quiet = 0;
  logic [62:0] clock_ns = 63'd1000;

  function automatic int find_pending(logic [31:0] dev, logic [47:0] sec, logic [22:0] cnt);
    for (int i = 0; i < NUM_PENDING; i++) begin
      if (pend_valid[i] && pend_dev[i] == dev && pend_sec[i] == sec && pend_cnt[i] == cnt)
        return i;
    end
    return -1;
  endfunction

  function automatic int claim_pending(logic [31:0] dev, logic [47:0] sec, logic [22:0] cnt);
    int i;
    i = find_pending(dev, sec, cnt);
    if (i >= 0) return i;
    for (i = 0; i < NUM_PENDING; i++) begin
      if (!pend_valid[i]) begin
        pend_valid[i] = 1; pend_dev[i] = dev; pend_sec[i] = sec; pend_cnt[i] = cnt;
        pend_hins[i] = 0; pend_hiss[i] = 0; pend_tins[i] = '0; pend_tiss[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int find_slot(logic [31:0] dev);
    for (int i = 0; i < NUM_DEVS; i++) begin
      if (slot_valid[i] && slot_id[i] == dev) return i;
    end
    return -1;
  endfunction

  function automatic int claim_slot(logic [31:0] dev);
    int i;
    i = find_slot(dev);
    if (i >= 0) return i;
    for (i = 0; i < NUM_DEVS; i++) begin
      if (!slot_valid[i]) begin
        slot_valid[i] = 1; slot_id[i] = dev; slot_depth[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  task automatic track_request(input row_t t, output record_t r, output bit has_rec);
    int e;
    int d;
    r = '{default: '0};
    has_rec = (t.kind != KIND_NONE);
    d = -1;
    if (t.kind == KIND_INSERT) begin
      e = claim_pending(t.dev, t.sector, t.count);
      if (e >= 0) begin
        pend_hins[e] = 1; pend_tins[e] = t.ts;
      end
      d = find_slot(t.dev);
      r.bytes = t.bytes;
    end else if (t.kind == KIND_ISSUE) begin
      e = claim_pending(t.dev, t.sector, t.count);
      if (e >= 0) begin
        pend_hiss[e] = 1; pend_tiss[e] = t.ts;
      end
      d = claim_slot(t.dev);
      if (d >= 0 && slot_depth[d] != DEPTH_MAX) slot_depth[d]++;
      r.bytes = t.bytes;
    end else if (t.kind == KIND_COMPLETE) begin
      r.bytes = {t.count, 9'd0};
      r.err = t.err;
      e = find_pending(t.dev, t.sector, t.count);
      if (e >= 0) begin
        if (pend_hiss[e]) begin
          if (t.ts >= pend_tiss[e]) r.dev_lat = t.ts - pend_tiss[e];
          if (pend_hins[e] && pend_tiss[e] >= pend_tins[e])
            r.q_lat = pend_tiss[e] - pend_tins[e];
        end
        pend_valid[e] = 0; pend_hins[e] = 0; pend_hiss[e] = 0;
      end
      d = find_slot(t.dev);
      if (d >= 0 && slot_depth[d] != 0) slot_depth[d]--;
    end
    r.kind = t.kind;
    r.major = t.dev[31:20];
    r.minor = t.dev[19:0];
    r.sector = t.sector;
    r.count = t.count;
    if (d >= 0) r.depth = slot_depth[d];
  endtask

  // Hold the transaction until accepted, then predict and queue its record.
  task automatic send_request(input row_t t);
    record_t r;
    bit has_rec;
    start <= 1'b1;
    req_type <= t.kind;
    device_number <= t.dev;
    start_sector <= t.sector;
    sector_count <= t.count;
    byte_count <= t.bytes;
    error_code <= t.err;
    timestamp_ns <= t.ts;
    do @(posedge clk); while (busy);
    kind_count[t.kind]++;
    track_request(t, r, has_rec);
    if (has_rec) begin
      if (t.typed) begin
        r.dev_lat = t.dev_lat; r.q_lat = t.q_lat; r.depth = t.depth;
      end
      expected_records.push_back(r);
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic cmp(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    record_t x;
    if (!rst && done) begin
      if (expected_records.size() == 0) begin
        $display("%0t unexpected record: expected none actual kind %0d", $time, event_kind);
        errors++;
      end else begin
        x = expected_records.pop_front();
        cmp("event_kind", x.kind, event_kind);
        cmp("dev_major", x.major, dev_major);
        cmp("dev_minor", x.minor, dev_minor);
        cmp("out_sector", x.sector, out_sector);
        cmp("out_count", x.count, out_count);
        cmp("out_bytes", x.bytes, out_bytes);
        cmp("out_error", x.err, $unsigned(out_error));
        cmp("device_latency_ns", x.dev_lat, device_latency_ns);
        cmp("queue_latency_ns", x.q_lat, queue_latency_ns);
        cmp("queue_depth", x.depth, queue_depth);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic row_t mk(logic [1:0] k, logic [31:0] dev, logic [47:0] sec,
                              logic [22:0] cnt, logic [31:0] b, logic [12:0] err,
                              logic [62:0] ts, bit typed, logic [62:0] lat,
                              logic [62:0] ql, logic [15:0] dp);
    row_t t;
    t.kind = k; t.dev = dev; t.sector = sec; t.count = cnt; t.bytes = b; t.err = err;
    t.ts = ts; t.typed = typed; t.dev_lat = lat; t.q_lat = ql; t.depth = dp;
    return t;
  endfunction

  function automatic row_t rand_row(logic [1:0] k, req_key_t key);
    row_t t;
    t = mk(k, key.dev, key.sector, key.count, $urandom, 13'(-$urandom_range(0, 4095)),
           clock_ns, 0, '0, '0, '0);
    case ($urandom_range(0, 19))
      0: t.ts = 63'({$urandom, $urandom});
      1, 2: t.ts = clock_ns - 63'($urandom_range(1, 20000));
      default: t.ts = clock_ns;
    endcase
    return t;
  endfunction

  function automatic req_key_t rand_key();
    req_key_t k;
    k.dev = dev_pool[$urandom_range(0, 23)];
    k.sector = 48'({$urandom, $urandom});
    k.count = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 256));
    return k;
  endfunction

  row_t dir_rows [$];
  localparam logic [31:0] DEV_A = 32'h0080_0010;

  initial begin
    int n;
    int pick;
    req_key_t key;
    dir_rows = '{
      mk(KIND_COMPLETE, 32'h0, 48'h0, 23'h0, 32'h0, 13'h0, 63'd0, 1, 0, 0, 0),
      mk(KIND_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 23'h7F_FFFF, 32'hFFFF_FFFF,
         13'(-4095), 63'd100, 1, 0, 0, 0),
      mk(KIND_ISSUE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 23'h7F_FFFF, 32'h0,
         13'h0, 63'd250, 1, 0, 0, 1),
      mk(KIND_COMPLETE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 23'h7F_FFFF, 32'h0,
         13'(-4095), 63'd1000, 1, 750, 150, 0),
      mk(KIND_INSERT, DEV_A, 48'd1, 23'd8, 32'd4096, 13'h0, 63'd500, 1, 0, 0, 0),
      mk(KIND_INSERT, DEV_A, 48'd1, 23'd8, 32'd4096, 13'h0, 63'd600, 1, 0, 0, 0),
      mk(KIND_ISSUE, DEV_A, 48'd1, 23'd8, 32'd4096, 13'h0, 63'd900, 1, 0, 0, 1),
      mk(KIND_COMPLETE, DEV_A, 48'd1, 23'd8, 32'd0, 13'(-5), 63'd2000, 1, 1100, 300, 0),
      mk(KIND_ISSUE, DEV_A, 48'd2, 23'd1, 32'd512, 13'h0, 63'd5000, 1, 0, 0, 1),
      mk(KIND_COMPLETE, DEV_A, 48'd2, 23'd1, 32'd0, 13'h0, 63'd4000, 1, 0, 0, 0),
      mk(KIND_INSERT, DEV_A, 48'd3, 23'd2, 32'd1024, 13'h0, 63'd9000, 1, 0, 0, 0),
      mk(KIND_ISSUE, DEV_A, 48'd3, 23'd2, 32'd1024, 13'h0, 63'd8000, 1, 0, 0, 1),
      mk(KIND_COMPLETE, DEV_A, 48'd3, 23'd2, 32'd0, 13'h0, 63'd9500, 1, 1500, 0, 0),
      mk(KIND_INSERT, DEV_A, 48'd4, 23'd4, 32'd2048, 13'h0, 63'd1, 1, 0, 0, 0),
      mk(KIND_COMPLETE, DEV_A, 48'd4, 23'd4, 32'd0, 13'h0, 63'd10, 1, 0, 0, 0),
      mk(KIND_NONE, DEV_A, 48'd5, 23'd4, 32'd0, 13'h0, 63'd20, 0, 0, 0, 0),
      mk(KIND_COMPLETE, DEV_A, 48'd9, 23'd3, 32'd0, 13'(-1), 63'd30, 1, 0, 0, 0),
      mk(KIND_ISSUE, 32'h0, 48'h0, 23'h0, 32'h0, 13'h0, 63'h7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 1),
      mk(KIND_COMPLETE, 32'h0, 48'h0, 23'h0, 32'h0, 13'h0, 63'h7FFF_FFFF_FFFF_FFFF,
         1, 0, 0, 0)
    };
    dev_pool[0] = 32'h0;
    dev_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) dev_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    n = 0;
    while (n < RAND_ITEMS) begin
      quiet = (n > RAND_ITEMS - 200);
      clock_ns = clock_ns + $urandom_range(1, 5000);
      if (n == 600) begin
        // fill the pending table past capacity, then drain it down to 20 open keys
        for (int i = 0; i < NUM_PENDING + 12; i++) begin
          key = rand_key();
          open_keys.push_back(key);
          clock_ns = clock_ns + $urandom_range(1, 100);
          send_request(rand_row(($urandom_range(0, 4) == 0) ? KIND_ISSUE : KIND_INSERT, key));
          n++;
        end
        while (open_keys.size() > 20) begin
          key = open_keys.pop_front();
          clock_ns = clock_ns + $urandom_range(1, 100);
          send_request(rand_row(KIND_COMPLETE, key));
          n++;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 30 || open_keys.size() == 0) begin
        key = rand_key();
        open_keys.push_back(key);
        send_request(rand_row(($urandom_range(0, 4) == 0) ? KIND_ISSUE : KIND_INSERT, key));
      end else if (pick < 55) begin
        key = open_keys[$urandom_range(0, open_keys.size() - 1)];
        send_request(rand_row(KIND_ISSUE, key));
      end else if (pick < 85) begin
        pick = $urandom_range(0, open_keys.size() - 1);
        key = open_keys[pick];
        open_keys.delete(pick);
        send_request(rand_row(KIND_COMPLETE, key));
      end else begin
        key = rand_key();
        send_request(rand_row(2'($urandom_range(0, 3)), key));
      end
      n++;
    end
    start <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (NUM_PENDING + 40) @(posedge clk);
    $display("covered %0d inserts, %0d issues, %0d completes, %0d ignored kinds",
             kind_count[KIND_INSERT], kind_count[KIND_ISSUE],
             kind_count[KIND_COMPLETE], kind_count[KIND_NONE]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
